// ===== rtl/pwq_pkg.sv =====
// ----------------------------------------------------------------------------
// pwq_pkg
// Shared types, register indexes and CORDIC constants for the wide polyline
// quad expansion block.
// ----------------------------------------------------------------------------
package pwq_pkg;

  // one input transaction
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic               line_start;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_z;
    logic               last_vertex;
  } out_item_t;

  // segment endpoints in world coordinates, Q16.16
  typedef struct packed {
    logic signed [31:0] x1;
    logic signed [31:0] z1;
    logic signed [31:0] x2;
    logic signed [31:0] z2;
  } seg_t;

  // configuration register file
  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [23:0]        scale_factor;
  } cfg_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR = 2'd2;

  localparam logic [23:0] SCALE_RESET = 24'd65536;

  localparam int QUEUE_DEPTH = 2;

  localparam int HALF_WIDTH_MUL = 5;
  localparam int MAX_STEPS      = 32;

  // CORDIC gain compensation and unit length, Q2.30
  localparam logic signed [59:0] CORDIC_GAIN_Q30 = 60'sd652032874;
  localparam logic signed [59:0] ONE_Q30         = 60'sd1073741824;

  // arctangent of 2^-i in binary angle units (2^32 = full turn)
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:  val = 32'd536870912;
      5'd1:  val = 32'd316933406;
      5'd2:  val = 32'd167458907;
      5'd3:  val = 32'd85004756;
      5'd4:  val = 32'd42667331;
      5'd5:  val = 32'd21354465;
      5'd6:  val = 32'd10679838;
      5'd7:  val = 32'd5340245;
      5'd8:  val = 32'd2670163;
      5'd9:  val = 32'd1335087;
      5'd10: val = 32'd667544;
      5'd11: val = 32'd333772;
      5'd12: val = 32'd166886;
      5'd13: val = 32'd83443;
      5'd14: val = 32'd41722;
      5'd15: val = 32'd20861;
      5'd16: val = 32'd10430;
      5'd17: val = 32'd5215;
      5'd18: val = 32'd2608;
      5'd19: val = 32'd1304;
      5'd20: val = 32'd652;
      5'd21: val = 32'd326;
      5'd22: val = 32'd163;
      5'd23: val = 32'd81;
      5'd24: val = 32'd41;
      5'd25: val = 32'd20;
      5'd26: val = 32'd10;
      5'd27: val = 32'd5;
      5'd28: val = 32'd3;
      5'd29: val = 32'd1;
      5'd30: val = 32'd1;
      default: val = 32'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/pwq_front.sv =====
// ----------------------------------------------------------------------------
// pwq_front
// Accepts points, maps them to world coordinates on one shared multiplier,
// keeps the previous point and queues a segment for every continuing point.
// ----------------------------------------------------------------------------
module pwq_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pwq_pkg::in_item_t in_data,
  input  pwq_pkg::cfg_t     cfg,
  output logic              push_valid,
  input  logic              push_ready,
  output pwq_pkg::seg_t     push_data
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_MAPX,
    F_MAPZ,
    F_PUSH
  } fstate_t;

  fstate_t            state;
  pwq_pkg::in_item_t  item;
  logic signed [31:0] x2;
  logic signed [31:0] z2;
  logic signed [31:0] prev_x;
  logic signed [31:0] prev_z;
  logic               have_prev;

  logic signed [32:0] diff;
  logic signed [24:0] scale_s;
  logic signed [57:0] prod;
  logic signed [57:0] shifted;
  logic signed [31:0] mapped;
  logic               emit;

  // map x for the first multiply, z for the second
  always_comb begin
    if (state == F_MAPX) begin
      diff = {item.point_x[31], item.point_x} - {cfg.origin_x[31], cfg.origin_x};
    end else begin
      diff = {cfg.origin_y[31], cfg.origin_y} - {item.point_y[31], item.point_y};
    end
  end

  assign scale_s = $signed({1'b0, cfg.scale_factor});
  assign prod    = diff * scale_s;
  assign shifted = (prod + 58'sd128) >>> 8;

  always_comb begin
    if (shifted[57:31] == {27{shifted[57]}}) begin
      mapped = shifted[31:0];
    end else if (shifted[57]) begin
      mapped = 32'sh8000_0000;
    end else begin
      mapped = 32'sh7fff_ffff;
    end
  end

  assign emit       = !item.line_start && have_prev;
  assign in_ready   = (state == F_IDLE);
  assign push_valid = (state == F_PUSH) && emit;
  assign push_data  = '{x1: prev_x, z1: prev_z, x2: x2, z2: z2};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      have_prev <= 1'b0;
      prev_x    <= '0;
      prev_z    <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            state <= F_MAPX;
          end
        end
        F_MAPX: begin
          x2    <= mapped;
          state <= F_MAPZ;
        end
        F_MAPZ: begin
          z2    <= mapped;
          state <= F_PUSH;
        end
        F_PUSH: begin
          // hold a pending segment until the queue has room, then advance the previous point
          if (!emit || push_ready) begin
            prev_x    <= x2;
            prev_z    <= z2;
            have_prev <= 1'b1;
            state     <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/pwq_fifo.sv =====
// ----------------------------------------------------------------------------
// pwq_fifo
// Short segment queue between the front and the back.
// ----------------------------------------------------------------------------
module pwq_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  pwq_pkg::seg_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output pwq_pkg::seg_t pop_data
);

  localparam int DEPTH = pwq_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  pwq_pkg::seg_t  mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count beyond depth");

  a_push_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a push");

  a_pop_tracks: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not follow a pop");
`endif

endmodule

// ===== rtl/pwq_back.sv =====
// ----------------------------------------------------------------------------
// pwq_back
// Takes one segment at a time: CORDIC vectoring for its direction, CORDIC
// rotation for cos and sin, half-width offsets, then six quad vertices.
// ----------------------------------------------------------------------------
module pwq_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  pwq_pkg::seg_t      seg_in,
  input  logic [23:0]        scale_factor,
  output logic               out_valid,
  input  logic               out_ready,
  output pwq_pkg::out_item_t out_data
);

  localparam int NSTEP = (CORDIC_STEPS > pwq_pkg::MAX_STEPS) ? pwq_pkg::MAX_STEPS
                                                              : CORDIC_STEPS;
  localparam int SW = $clog2(NSTEP);
  localparam logic [SW-1:0] LAST_STEP = SW'(NSTEP - 1);
  localparam logic [2:0]    LAST_VTX  = 3'd5;

  typedef enum logic [2:0] {
    B_IDLE,
    B_VEC,
    B_PREP,
    B_ROT,
    B_MULC,
    B_MULS,
    B_EMIT
  } bstate_t;

  bstate_t            state;
  pwq_pkg::seg_t      seg;
  logic signed [59:0] cx;
  logic signed [59:0] cy;
  logic signed [33:0] cz;
  logic [SW-1:0]      step;
  logic               flip;
  logic signed [33:0] xoff;
  logic signed [33:0] yoff;
  logic [2:0]         vtx;

  // segment load
  logic signed [32:0] dx;
  logic signed [32:0] dz;
  logic signed [59:0] vx0;
  logic signed [59:0] vz0;

  // CORDIC step
  logic               ccw;
  logic signed [59:0] xs;
  logic signed [59:0] ys;
  logic signed [33:0] tab;

  // rotation quadrant fold
  logic signed [33:0] ang;

  // offset multiply
  logic [26:0]        half_w;
  logic signed [32:0] trig;
  logic signed [60:0] oprod;
  logic signed [60:0] orounded;

  // vertex build
  logic               use_p2;
  logic               neg_side;
  logic signed [34:0] vsum_x;
  logic signed [34:0] vsum_z;

  function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v[34:31] == {4{v[34]}}) begin
      r = v[31:0];
    end else if (v[34]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  assign dx  = {seg_in.x2[31], seg_in.x2} - {seg_in.x1[31], seg_in.x1};
  assign dz  = {seg_in.z2[31], seg_in.z2} - {seg_in.z1[31], seg_in.z1};
  assign vx0 = {{3{dx[32]}}, dx, 24'd0};
  assign vz0 = {{3{dz[32]}}, dz, 24'd0};

  // vectoring drives y to zero, rotation drives the angle to zero
  assign ccw = (state == B_ROT) ? !cz[33] : cy[59];
  assign xs  = cx >>> step;
  assign ys  = cy >>> step;
  assign tab = $signed({2'b00, pwq_pkg::atan_lut(5'(step))});

  assign ang = {{2{cz[31]}}, cz[31:0]};

  assign half_w   = 27'(scale_factor) * 27'(pwq_pkg::HALF_WIDTH_MUL);
  assign trig     = flip ? -((state == B_MULC) ? cx[32:0] : cy[32:0])
                         :  ((state == B_MULC) ? cx[32:0] : cy[32:0]);
  assign oprod    = trig * $signed({1'b0, half_w});
  assign orounded = (oprod + 61'sd536870912) >>> 30;

  // order v1,v2,v3,v1,v3,v4
  assign use_p2   = (vtx == 3'd1) || (vtx == 3'd2) || (vtx == 3'd4);
  assign neg_side = (vtx == 3'd2) || (vtx == 3'd4) || (vtx == 3'd5);
  assign vsum_x = 35'(use_p2 ? seg.x2 : seg.x1)
                + (neg_side ? 35'(yoff) : -35'(yoff));
  assign vsum_z = 35'(use_p2 ? seg.z2 : seg.z1)
                + (neg_side ? -35'(xoff) : 35'(xoff));

  assign pop_ready = (state == B_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      // the emit state refills the output register itself
      if (out_valid && out_ready && state != B_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop_valid) begin
            seg  <= seg_in;
            step <= '0;
            flip <= 1'b0;
            if (dx == '0 && dz == '0) begin
              // zero-length segment: angle 0 exactly
              cx    <= pwq_pkg::ONE_Q30;
              cy    <= '0;
              state <= B_MULC;
            end else if (dx[32]) begin
              cx    <= -vx0;
              cy    <= -vz0;
              cz    <= 34'sh0_8000_0000;
              state <= B_VEC;
            end else begin
              cx    <= vx0;
              cy    <= vz0;
              cz    <= '0;
              state <= B_VEC;
            end
          end
        end
        B_VEC, B_ROT: begin
          cx <= ccw ? cx - ys : cx + ys;
          cy <= ccw ? cy + xs : cy - xs;
          cz <= ccw ? cz - tab : cz + tab;
          if (step == LAST_STEP) begin
            step  <= '0;
            state <= (state == B_VEC) ? B_PREP : B_MULC;
          end else begin
            step <= step + 1'b1;
          end
        end
        B_PREP: begin
          // fold the angle into the right half plane
          if (ang > 34'sh0_4000_0000) begin
            cz   <= ang - 34'sh0_8000_0000;
            flip <= 1'b1;
          end else if (ang < -34'sh0_4000_0000) begin
            cz   <= ang + 34'sh0_8000_0000;
            flip <= 1'b1;
          end else begin
            cz   <= ang;
            flip <= 1'b0;
          end
          cx    <= pwq_pkg::CORDIC_GAIN_Q30;
          cy    <= '0;
          state <= B_ROT;
        end
        B_MULC: begin
          xoff  <= orounded[33:0];
          state <= B_MULS;
        end
        B_MULS: begin
          yoff  <= orounded[33:0];
          vtx   <= '0;
          state <= B_EMIT;
        end
        B_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid            <= 1'b1;
            out_data.vertex_x    <= sat35(vsum_x);
            out_data.vertex_z    <= sat35(vsum_z);
            out_data.last_vertex <= (vtx == LAST_VTX);
            if (vtx == LAST_VTX) begin
              state <= B_IDLE;
            end else begin
              vtx <= vtx + 1'b1;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_hold_while_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("vertex changed while stalled");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    (state != B_IDLE) |-> !pop_ready)
    else $error("segment taken while busy");

  a_emit_once: assert property (@(posedge clk) disable iff (rst)
    (state == B_EMIT && vtx == LAST_VTX && (!out_valid || out_ready)) |=>
      (state == B_IDLE && out_data.last_vertex))
    else $error("last vertex did not close the segment");
`endif

endmodule

// ===== rtl/polyline_to_wide_quads_top.sv =====
// Output: the vertices of a segment leave one vertex a cycle while out_ready
// is high. The back part takes a new segment only when its shared CORDIC
// unit is through with the last; zero-length segments skip that unit, and
// a line start queues no segment.
// Reset (rst, synchronous): clears the previous point, the queue and the
// configuration (origins 0, scale 1.0).
// ----------------------------------------------------------------------------
// polyline_to_wide_quads_top
// Expands polyline points into two triangles of a wide quad per segment.
// ----------------------------------------------------------------------------
module polyline_to_wide_quads_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  pwq_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pwq_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [pwq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pwq_pkg::CFG_DATA_W-1:0] cfg_data
);

  pwq_pkg::cfg_t cfg;
  logic          push_valid;
  logic          push_ready;
  pwq_pkg::seg_t push_data;
  logic          pop_valid;
  logic          pop_ready;
  pwq_pkg::seg_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x     <= '0;
      cfg.origin_y     <= '0;
      cfg.scale_factor <= pwq_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pwq_pkg::REG_ORIGIN_X:     cfg.origin_x     <= cfg_data;
        pwq_pkg::REG_ORIGIN_Y:     cfg.origin_y     <= cfg_data;
        pwq_pkg::REG_SCALE_FACTOR: cfg.scale_factor <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  pwq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  pwq_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  pwq_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .seg_in       (pop_data),
    .scale_factor (cfg.scale_factor),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule
